// File: rtl/imd_pkg.sv
// shared types, constants and sine table for the iq mixer and decimator
package imd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int PHASE_W     = 32;
    localparam int ROM_ADDR_W  = 10;
    localparam int ROM_SIZE    = 1 << ROM_ADDR_W;
    localparam int QTR_DEPTH   = ROM_SIZE / 4 + 1;
    localparam int QTR_IDX_W   = ROM_ADDR_W - 1;

    localparam int MAX_DEC     = 256;
    localparam int CNT_W       = $clog2(MAX_DEC);
    localparam int DEC_W       = 9;
    localparam int GAIN_W      = 17;

    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int ACC_W       = SUM_W + CNT_W;
    localparam int SPLIT_W     = 24;
    localparam int HI_W        = ACC_W - SPLIT_W;
    localparam int SCALE_W     = ACC_W + GAIN_W + 1;
    localparam int OUT_SHIFT   = 31;
    localparam int QUOT_W      = SCALE_W - OUT_SHIFT;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_GAIN = CFG_IDX_W'(2);

    localparam logic [DEC_W-1:0]  DEC_RESET  = DEC_W'(1);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

    localparam int TAYLOR_TERMS = 40;
    localparam int AMPLITUDE    = 32767;
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

    typedef logic [63:0] q62_t;
    typedef q62_t denom_arr_t [TAYLOR_TERMS];
    typedef logic signed [SAMPLE_W-1:0] qtab_t [QTR_DEPTH];

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_i;
        logic signed [SAMPLE_W-1:0] x_q;
        logic signed [SAMPLE_W-1:0] sin_v;
        logic signed [SAMPLE_W-1:0] cos_v;
        logic                       last;
    } work_t;

    function automatic denom_arr_t build_denom();
        denom_arr_t d;
        for (int k = 0; k < TAYLOR_TERMS; k++)
        begin
            d[k] = q62_t'((2 * k + 2) * (2 * k + 3));
        end
        return d;
    endfunction

    localparam denom_arr_t DENOM = build_denom();

    // q62 product, low 64 bits of the shifted result
    function automatic q62_t qmul(input q62_t a, input q62_t b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // quarter wave of round(amplitude * sin), taylor series in q62
    function automatic qtab_t build_qtab();
        qtab_t t;
        q62_t  x;
        q62_t  x2;
        q62_t  term;
        q62_t  sum;
        q62_t  r;
        logic  done;
        for (int j = 0; j < QTR_DEPTH; j++)
        begin
            x    = qmul(PI_Q62, q62_t'(j) << (63 - ROM_ADDR_W));
            x2   = qmul(x, x);
            term = x;
            sum  = x;
            done = 1'b0;
            for (int k = 0; k < TAYLOR_TERMS; k++)
            begin
                if (!done)
                begin
                    term = qmul(term, x2) / DENOM[k];
                    if (term == '0)
                        done = 1'b1;
                    else if (k[0])
                        sum = sum + term;
                    else
                        sum = sum - term;
                end
            end
            r    = (sum >> 20) * q62_t'(AMPLITUDE);
            r    = (r + (q62_t'(1) << 41)) >> 42;
            t[j] = r[SAMPLE_W-1:0];
        end
        return t;
    endfunction

    localparam qtab_t QSINE = build_qtab();

    // full-wave lookup through quarter-wave symmetry
    function automatic logic signed [SAMPLE_W-1:0] sine_at(input logic [ROM_ADDR_W-1:0] addr);
        logic [QTR_IDX_W-1:0]       h;
        logic [QTR_IDX_W-1:0]       j;
        logic signed [SAMPLE_W-1:0] v;
        h = addr[QTR_IDX_W-1:0];
        if (h <= QTR_IDX_W'(ROM_SIZE / 4))
            j = h;
        else
            j = QTR_IDX_W'(ROM_SIZE / 2 - int'(h));
        v = QSINE[j];
        return addr[ROM_ADDR_W-1] ? -v : v;
    endfunction

endpackage

// File: rtl/imd_front.sv
// front end: takes samples, steps the oscillator phase, looks up sin and cos, marks block ends
module imd_front
    import imd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic signed [SAMPLE_W-1:0] in_i,
    input  logic signed [SAMPLE_W-1:0] in_q,
    input  logic [PHASE_W-1:0]         phase_step,
    input  logic [DEC_W-1:0]           decimation,
    input  logic                       q_full,
    output logic                       q_wr_en,
    output work_t                      q_wr_data
);

    logic [PHASE_W-1:0]    phase_reg;
    logic [PHASE_W-1:0]    phase_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [ROM_ADDR_W-1:0] sin_addr;
    logic [ROM_ADDR_W-1:0] cos_addr;
    logic [CNT_W:0]        cnt_plus;
    logic [CNT_W:0]        dec_eff;
    logic                  last;

    assign q_wr_en  = push && !q_full;
    assign sin_addr = phase_reg[PHASE_W-1 -: ROM_ADDR_W];
    assign cos_addr = sin_addr + ROM_ADDR_W'(ROM_SIZE / 4);
    assign cnt_plus = (CNT_W + 1)'(count_reg) + (CNT_W + 1)'(1);

    always_comb
    begin
        if (decimation == '0)
            dec_eff = (CNT_W + 1)'(1);
        else if (decimation > DEC_W'(MAX_DEC))
            dec_eff = (CNT_W + 1)'(MAX_DEC);
        else
            dec_eff = (CNT_W + 1)'(decimation);
    end

    assign last = cnt_plus >= dec_eff;

    always_comb
    begin
        q_wr_data.x_i   = in_i;
        q_wr_data.x_q   = in_q;
        q_wr_data.sin_v = sine_at(sin_addr);
        q_wr_data.cos_v = sine_at(cos_addr);
        q_wr_data.last  = last;
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (q_wr_en)
        begin
            phase_next = phase_reg + phase_step;
            count_next = last ? '0 : cnt_plus[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/imd_queue.sv
// short queue of work words between the front end and the back end
module imd_queue
    import imd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  work_t wr_data,
    output logic  full,
    output logic  rd_valid,
    input  logic  rd_en,
    output work_t rd_data
);

    work_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   cnt_reg;
    logic [QUEUE_PTR_W:0]   cnt_next;

    assign full     = cnt_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/imd_back.sv
// back end: complex mix, boxcar accumulate, gain scaling with saturation, result buffer
module imd_back
    import imd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  work_t                      head,
    input  logic                       head_valid,
    output logic                       head_pop,
    input  logic [GAIN_W-1:0]          average_gain,
    input  logic                       pop,
    output logic                       empty,
    output logic signed [SAMPLE_W-1:0] out_i,
    output logic signed [SAMPLE_W-1:0] out_q
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] i;
        logic signed [SAMPLE_W-1:0] q;
    } res_t;

    localparam logic signed [QUOT_W-1:0] POS_LIM = QUOT_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [QUOT_W-1:0] NEG_LIM = QUOT_W'(-(1 << (SAMPLE_W - 1)));

    function automatic logic signed [SAMPLE_W-1:0] sat(input logic signed [QUOT_W-1:0] v);
        if (v > POS_LIM)
            return POS_LIM[SAMPLE_W-1:0];
        else if (v < NEG_LIM)
            return NEG_LIM[SAMPLE_W-1:0];
        else
            return v[SAMPLE_W-1:0];
    endfunction

    // stage a: products
    logic                       a_valid_reg;
    logic                       a_last_reg;
    logic signed [PROD_W-1:0]   pic_reg;
    logic signed [PROD_W-1:0]   pqs_reg;
    logic signed [PROD_W-1:0]   pis_reg;
    logic signed [PROD_W-1:0]   pqc_reg;

    // stage b: accumulate
    logic signed [SUM_W-1:0]    sum_i;
    logic signed [SUM_W-1:0]    sum_q;
    logic signed [ACC_W-1:0]    acc_i_sum;
    logic signed [ACC_W-1:0]    acc_q_sum;
    logic signed [ACC_W-1:0]    acc_i_reg;
    logic signed [ACC_W-1:0]    acc_q_reg;
    logic signed [ACC_W-1:0]    acc_i_next;
    logic signed [ACC_W-1:0]    acc_q_next;
    logic                       b_valid_reg;
    logic signed [ACC_W-1:0]    fin_i_reg;
    logic signed [ACC_W-1:0]    fin_q_reg;

    // stage c: split gain products
    logic                             c_valid_reg;
    logic signed [HI_W+GAIN_W:0]      ph_i_reg;
    logic signed [HI_W+GAIN_W:0]      ph_q_reg;
    logic [SPLIT_W+GAIN_W-1:0]        pl_i_reg;
    logic [SPLIT_W+GAIN_W-1:0]        pl_q_reg;
    logic signed [GAIN_W:0]           gain_s;

    // stage d: combine, shift, saturate
    logic signed [SCALE_W-1:0]  full_i;
    logic signed [SCALE_W-1:0]  full_q;
    res_t                       res_word;

    // result buffer
    res_t                       out_mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]       out_wr_reg;
    logic [OUT_PTR_W-1:0]       out_rd_reg;
    logic [OUT_CNT_W-1:0]       out_cnt_reg;
    logic [OUT_CNT_W-1:0]       out_cnt_next;
    logic [OUT_CNT_W-1:0]       reserved_reg;
    logic [OUT_CNT_W-1:0]       reserved_next;
    logic                       out_take;
    logic                       res_claim;

    // a block end only leaves the queue once a result slot is reserved for it
    assign head_pop  = head_valid && (!head.last || reserved_reg < OUT_CNT_W'(OUT_DEPTH));
    assign res_claim = head_pop && head.last;
    assign out_take  = pop && !empty;

    assign sum_i     = SUM_W'(pic_reg) - SUM_W'(pqs_reg);
    assign sum_q     = SUM_W'(pis_reg) + SUM_W'(pqc_reg);
    assign acc_i_sum = acc_i_reg + ACC_W'(sum_i);
    assign acc_q_sum = acc_q_reg + ACC_W'(sum_q);

    always_comb
    begin
        acc_i_next = acc_i_reg;
        acc_q_next = acc_q_reg;
        if (a_valid_reg)
        begin
            acc_i_next = a_last_reg ? '0 : acc_i_sum;
            acc_q_next = a_last_reg ? '0 : acc_q_sum;
        end
    end

    assign gain_s = $signed({1'b0, average_gain});

    assign full_i = (SCALE_W'(ph_i_reg) <<< SPLIT_W) + SCALE_W'($signed({1'b0, pl_i_reg}));
    assign full_q = (SCALE_W'(ph_q_reg) <<< SPLIT_W) + SCALE_W'($signed({1'b0, pl_q_reg}));

    always_comb
    begin
        res_word.i = sat(full_i[SCALE_W-1:OUT_SHIFT]);
        res_word.q = sat(full_q[SCALE_W-1:OUT_SHIFT]);
    end

    assign empty = out_cnt_reg == '0;
    assign out_i = out_mem_reg[out_rd_reg].i;
    assign out_q = out_mem_reg[out_rd_reg].q;

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (c_valid_reg && !out_take)
            out_cnt_next = out_cnt_reg + 1'b1;
        else if (!c_valid_reg && out_take)
            out_cnt_next = out_cnt_reg - 1'b1;
    end

    always_comb
    begin
        reserved_next = reserved_reg;
        if (res_claim && !out_take)
            reserved_next = reserved_reg + 1'b1;
        else if (!res_claim && out_take)
            reserved_next = reserved_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        pic_reg <= head.x_i * head.cos_v;
        pqs_reg <= head.x_q * head.sin_v;
        pis_reg <= head.x_i * head.sin_v;
        pqc_reg <= head.x_q * head.cos_v;
        fin_i_reg <= acc_i_sum;
        fin_q_reg <= acc_q_sum;
        ph_i_reg <= $signed(fin_i_reg[ACC_W-1:SPLIT_W]) * gain_s;
        ph_q_reg <= $signed(fin_q_reg[ACC_W-1:SPLIT_W]) * gain_s;
        pl_i_reg <= fin_i_reg[SPLIT_W-1:0] * average_gain;
        pl_q_reg <= fin_q_reg[SPLIT_W-1:0] * average_gain;
        if (c_valid_reg)
            out_mem_reg[out_wr_reg] <= res_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            a_last_reg   <= 1'b0;
            acc_i_reg    <= '0;
            acc_q_reg    <= '0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            out_wr_reg   <= '0;
            out_rd_reg   <= '0;
            out_cnt_reg  <= '0;
            reserved_reg <= '0;
        end
        else
        begin
            a_valid_reg  <= head_pop;
            a_last_reg   <= head.last;
            acc_i_reg    <= acc_i_next;
            acc_q_reg    <= acc_q_next;
            b_valid_reg  <= a_valid_reg && a_last_reg;
            c_valid_reg  <= b_valid_reg;
            if (c_valid_reg)
                out_wr_reg <= out_wr_reg + 1'b1;
            if (out_take)
                out_rd_reg <= out_rd_reg + 1'b1;
            out_cnt_reg  <= out_cnt_next;
            reserved_reg <= reserved_next;
        end
    end

endmodule

// File: rtl/iq_mix_and_decimate.sv
// top level: register file, front end, work queue and back end of the iq mixer and decimator
// a block end passes the queue, product, sum and gain registers to the result buffer
// throughput: one input word per cycle unless full, one result per cycle at decimation one
// full rises only when the 4-entry work queue backs up behind 8 reserved result slots
// reset: phase, sample count, sums and both queues clear; registers take their reset values
module iq_mix_and_decimate
    import imd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic signed [SAMPLE_W-1:0] in_i,
    input  logic signed [SAMPLE_W-1:0] in_q,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] out_i,
    output logic signed [SAMPLE_W-1:0] out_q,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    logic [PHASE_W-1:0] phase_step_reg;
    logic [DEC_W-1:0]   decimation_reg;
    logic [GAIN_W-1:0]  average_gain_reg;
    logic               cfg_we;

    logic  q_wr_en;
    work_t q_wr_data;
    logic  q_full;
    logic  q_rd_valid;
    logic  q_rd_en;
    work_t q_rd_data;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign full      = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= '0;
            decimation_reg   <= DEC_RESET;
            average_gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_STEP:   phase_step_reg   <= cfg_data[PHASE_W-1:0];
                CFG_DECIMATION:   decimation_reg   <= cfg_data[DEC_W-1:0];
                CFG_AVERAGE_GAIN: average_gain_reg <= cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    imd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .in_i       (in_i),
        .in_q       (in_q),
        .phase_step (phase_step_reg),
        .decimation (decimation_reg),
        .q_full     (q_full),
        .q_wr_en    (q_wr_en),
        .q_wr_data  (q_wr_data)
    );

    imd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr_en),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .rd_valid (q_rd_valid),
        .rd_en    (q_rd_en),
        .rd_data  (q_rd_data)
    );

    imd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_rd_data),
        .head_valid   (q_rd_valid),
        .head_pop     (q_rd_en),
        .average_gain (average_gain_reg),
        .pop          (pop),
        .empty        (empty),
        .out_i        (out_i),
        .out_q        (out_q)
    );

endmodule

// File: verif/tb_top.sv
// testbench for the iq mixer and decimator: directed table, random phases and a predictor
module tb_top;
    import imd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_WORDS  = 1600;
    localparam int NDIR          = 28;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_DATA_W-1:0]      data;
        logic signed [SAMPLE_W-1:0] xi;
        logic signed [SAMPLE_W-1:0] xq;
        logic                       typed;
        logic signed [SAMPLE_W-1:0] ei;
        logic signed [SAMPLE_W-1:0] eq;
    } dir_row_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] oi;
        logic signed [SAMPLE_W-1:0] oq;
    } mixed_word_t;

    localparam dir_row_t DIRECTED [NDIR] = '{
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, 16'sd32767, 16'sd32767, 1'b1, 16'sd32766, 16'sd32766},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, -16'sd32768, -16'sd32768, 1'b1,
          -16'sd32767, -16'sd32767},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, 16'sd32767, -16'sd32768, 1'b1,
          16'sd32766, -16'sd32767},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, 16'sd1, -16'sd1, 1'b1, 16'sd0, -16'sd1},
        // write beyond the register list is dropped
        '{ROW_REG, CFG_SPARE, 32'hFFFFFFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, 16'sd32767, 16'sd0, 1'b1, 16'sd32766, 16'sd0},
        '{ROW_REG, CFG_AVERAGE_GAIN, 32'h0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, -16'sd32768, 16'sd32767, 1'b1, 16'sd0, 16'sd0},
        // gain above one saturates
        '{ROW_REG, CFG_AVERAGE_GAIN, 32'h0001FFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, 16'sd32767, -16'sd32768, 1'b1,
          16'sd32767, -16'sd32768},
        '{ROW_REG, CFG_AVERAGE_GAIN, 32'h00010000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        // decimation zero after masking
        '{ROW_REG, CFG_DECIMATION, 32'hFFFFFE00, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, 16'sd100, -16'sd100, 1'b1, 16'sd99, -16'sd100},
        '{ROW_REG, CFG_PHASE_STEP, 32'h40000000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, 16'sd1000, 16'sd2000, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, -16'sd32768, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG, CFG_PHASE_STEP, 32'h80000000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, 16'sd12345, -16'sd5432, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, 16'sd32767, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG, CFG_PHASE_STEP, 32'h7FFFFFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, -16'sd1, 16'sd1, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG, CFG_DECIMATION, 32'h00000004, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, 16'sd30000, 16'sd30000, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, -16'sd30000, 16'sd20000, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, 16'sd32767, -16'sd32768, 1'b0, 16'sd0, 16'sd0},
        // decimation lowered below the samples already taken
        '{ROW_REG, CFG_DECIMATION, 32'h00000002, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_WORD, CFG_PHASE_STEP, 32'h0, 16'sd500, 16'sd600, 1'b0, 16'sd0, 16'sd0}
    };

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       push      = 1'b0;
    logic                       full;
    logic signed [SAMPLE_W-1:0] in_i      = '0;
    logic signed [SAMPLE_W-1:0] in_q      = '0;
    logic                       empty;
    logic                       pop       = 1'b0;
    logic signed [SAMPLE_W-1:0] out_i;
    logic signed [SAMPLE_W-1:0] out_q;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;

    // predictor state
    logic signed [SAMPLE_W-1:0] sine_tab [ROM_SIZE];
    logic [PHASE_W-1:0]         nco_phase = '0;
    longint                     sum_i     = 0;
    longint                     sum_q     = 0;
    int unsigned                taken     = 0;
    logic [PHASE_W-1:0]         reg_step  = '0;
    logic [DEC_W-1:0]           reg_dec   = DEC_RESET;
    logic [GAIN_W-1:0]          reg_gain  = GAIN_RESET;

    mixed_word_t pending_out [$];
    int          fail_count = 0;
    bit          send_calm  = 1'b0;
    bit          pop_calm   = 1'b0;
    int          pop_stall  = 0;

    iq_mix_and_decimate i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_i      (in_i),
        .in_q      (in_q),
        .empty     (empty),
        .pop       (pop),
        .out_i     (out_i),
        .out_q     (out_q),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] scale_sum(input longint s,
                                                            input logic [GAIN_W-1:0] g);
        longint p;
        p = s * longint'(g);
        p = p >>> OUT_SHIFT;
        if (p > 32767)
            return 16'sd32767;
        else if (p < -32768)
            return -16'sd32768;
        return p[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'sd32767;
        else if (r == 1)
            return -16'sd32768;
        return SAMPLE_W'($urandom);
    endfunction

    task automatic mix_word(input logic signed [SAMPLE_W-1:0] xi,
                            input logic signed [SAMPLE_W-1:0] xq,
                            output bit done, output mixed_word_t w);
        logic [ROM_ADDR_W-1:0] a;
        longint                s;
        longint                c;
        int unsigned           lim;
        a = nco_phase[PHASE_W-1 -: ROM_ADDR_W];
        s = longint'(sine_tab[a]);
        c = longint'(sine_tab[a + ROM_ADDR_W'(ROM_SIZE / 4)]);
        sum_i = sum_i + longint'(xi) * c - longint'(xq) * s;
        sum_q = sum_q + longint'(xi) * s + longint'(xq) * c;
        nco_phase = nco_phase + reg_step;
        if (reg_dec == '0)
            lim = 1;
        else if (reg_dec > MAX_DEC)
            lim = MAX_DEC;
        else
            lim = 32'(reg_dec);
        taken = taken + 1;
        done = 1'b0;
        w = '0;
        if (taken >= lim)
        begin
            done = 1'b1;
            w.oi = scale_sum(sum_i, reg_gain);
            w.oq = scale_sum(sum_q, reg_gain);
            sum_i = 0;
            sum_q = 0;
            taken = 0;
        end
    endtask

    task automatic send_word(input logic signed [SAMPLE_W-1:0] xi,
                             input logic signed [SAMPLE_W-1:0] xq,
                             input logic typed, input mixed_word_t typed_w);
        int          gap;
        bit          done;
        mixed_word_t w;
        gap = send_calm ? 0 : idle_len();
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        in_i <= xi;
        in_q <= xq;
        do
            @(posedge clk);
        while (full);
        mix_word(xi, xq, done, w);
        if (done)
            pending_out.push_back(typed ? typed_w : w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        push <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_PHASE_STEP:   reg_step = d;
            CFG_DECIMATION:   reg_dec  = d[DEC_W-1:0];
            CFG_AVERAGE_GAIN: reg_gain = d[GAIN_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result side: random pop stalls, with calm stretches
    always @(negedge clk)
    begin
        if ($urandom_range(0, 499) == 0)
            pop_calm <= ~pop_calm;
        if (pop_stall > 0)
        begin
            pop <= 1'b0;
            pop_stall <= pop_stall - 1;
        end
        else
        begin
            pop <= 1'b1;
            pop_stall <= pop_calm ? 0 : idle_len();
        end
    end

    always @(posedge clk)
    begin
        mixed_word_t w;
        if (rst_n && pop && !empty)
        begin
            if (pending_out.size() == 0)
            begin
                $display("%0t unexpected word: expected none, actual out_i %0d out_q %0d",
                         $time, out_i, out_q);
                fail_count++;
            end
            else
            begin
                w = pending_out.pop_front();
                if (out_i !== w.oi)
                begin
                    $display("%0t out_i mismatch: expected %0d actual %0d", $time, w.oi, out_i);
                    fail_count++;
                end
                if (out_q !== w.oq)
                begin
                    $display("%0t out_q mismatch: expected %0d actual %0d", $time, w.oq, out_q);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int          h;
        int          j;
        int          v;
        int          sent;
        int          n;
        int unsigned d_eff;
        logic [CFG_DATA_W-1:0] dsel;
        logic [CFG_DATA_W-1:0] gsel;
        logic [CFG_DATA_W-1:0] ssel;
        mixed_word_t tw;

        // sine table from quarter-wave symmetry
        for (int a = 0; a < ROM_SIZE; a++)
        begin
            h = a % (ROM_SIZE / 2);
            j = (h <= ROM_SIZE / 4) ? h : ROM_SIZE / 2 - h;
            v = $rtoi(32767.0 * $sin(3.14159265358979323846 * j / (ROM_SIZE / 2)) + 0.5);
            sine_tab[a] = SAMPLE_W'((a >= ROM_SIZE / 2) ? -v : v);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NDIR; r++)
        begin
            if (DIRECTED[r].kind == ROW_REG)
                write_reg(DIRECTED[r].idx, DIRECTED[r].data);
            else
            begin
                tw.oi = DIRECTED[r].ei;
                tw.oq = DIRECTED[r].eq;
                send_word(DIRECTED[r].xi, DIRECTED[r].xq, DIRECTED[r].typed, tw);
            end
        end

        tw = '0;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0:       dsel = 32'd256;
                1:       dsel = 32'd511;
                2:       dsel = 32'd0;
                3:       dsel = 32'd1;
                4:       dsel = $urandom;
                default: dsel = $urandom_range(1, 16);
            endcase
            d_eff = (dsel[DEC_W-1:0] == 0) ? 1 :
                    (dsel[DEC_W-1:0] > MAX_DEC) ? MAX_DEC : dsel[DEC_W-1:0];
            case ($urandom_range(0, 5))
                0:       gsel = 32'd0;
                1:       gsel = 32'd65536;
                2:       gsel = 32'h0001FFFF;
                3:       gsel = $urandom;
                default: gsel = 65536 / d_eff;
            endcase
            case ($urandom_range(0, 5))
                0:       ssel = 32'h0;
                1:       ssel = 32'h80000000;
                2:       ssel = 32'h7FFFFFFF;
                3:       ssel = $urandom_range(0, 1 << 24);
                default: ssel = $urandom;
            endcase
            write_reg(CFG_DECIMATION, dsel);
            write_reg(CFG_AVERAGE_GAIN, gsel);
            write_reg(CFG_PHASE_STEP, ssel);
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_SPARE, $urandom);
            send_calm = ($urandom_range(0, 3) == 0);
            if (d_eff <= 16)
                n = $urandom_range(20, 100);
            else
                n = d_eff * $urandom_range(1, 2) + $urandom_range(0, 3);
            repeat (n)
                send_word(rand_sample(), rand_sample(), 1'b0, tw);
            sent += n;
        end

        @(negedge clk);
        push <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
rtl/imd_pkg.sv
rtl/imd_front.sv
rtl/imd_queue.sv
rtl/imd_back.sv
rtl/iq_mix_and_decimate.sv
verif/tb_top.sv
